>>> src/ile_pkg.sv
`default_nettype none
package ile_pkg;

  localparam int CAPACITY = 256;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int LEN_W    = 9;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  // width wide enough to compare a position against the fill count
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

  // read-out select tree: groups of cells, one registered level per group
  localparam int GRP_SIZE = (CAPACITY >= 16) ? 16 : CAPACITY;
  localparam int GROUPS   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int SUB_W    = $clog2(GRP_SIZE);
  localparam int GSEL_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_BEFORE = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [CMP_W-1:0]    pos;
    logic [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> src/ile_in_if.sv
`default_nettype none
interface ile_in_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     cmd;
  logic [ile_pkg::POS_W-1:0]      position;
  logic signed [ile_pkg::DATA_W-1:0] item_value;

  modport source (output valid, output cmd, output position, output item_value, input ready);
  modport sink   (input valid, input cmd, input position, input item_value, output ready);
endinterface
`default_nettype wire

>>> src/ile_out_if.sv
`default_nettype none
interface ile_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ile_pkg::DATA_W-1:0] read_value;
  logic [1:0]                        status;
  logic [ile_pkg::LEN_W-1:0]         length;

  modport source (output valid, output read_value, output status, output length, input ready);
  modport sink   (input valid, input read_value, input status, input length, output ready);
endinterface
`default_nettype wire

>>> src/ile_cell.sv
`default_nettype none
module ile_cell (
  input  wire logic                        clk,
  input  wire ile_pkg::cell_ctl_t          ctl,
  input  wire logic [ile_pkg::CMP_W-1:0]   idx,
  input  wire logic [ile_pkg::DATA_W-1:0]  left,
  input  wire logic [ile_pkg::DATA_W-1:0]  right,
  output logic [ile_pkg::DATA_W-1:0]       data
);

  logic [ile_pkg::DATA_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      ile_pkg::CELL_INS: begin
        if (idx > ctl.pos) begin
          data_next = left;
        end else if (idx == ctl.pos) begin
          data_next = ctl.value;
        end
      end
      ile_pkg::CELL_DEL: begin
        if (idx >= ctl.pos) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

>>> src/ile_rdmux.sv
`default_nettype none
module ile_rdmux (
  input  wire logic                                               clk,
  input  wire logic                                               load,
  input  wire logic [ile_pkg::CMP_W-1:0]                          pos,
  input  wire logic [ile_pkg::CAPACITY-1:0][ile_pkg::DATA_W-1:0]  cells,
  output logic [ile_pkg::DATA_W-1:0]                              word
);

  logic [ile_pkg::GRP_SIZE-1:0][ile_pkg::DATA_W-1:0] gw [ile_pkg::GROUPS];
  logic [ile_pkg::DATA_W-1:0]                        grp [ile_pkg::GROUPS];
  logic [ile_pkg::GSEL_W-1:0]                        gsel;

  for (genvar g = 0; g < ile_pkg::GROUPS; g++) begin : g_grp
    for (genvar s = 0; s < ile_pkg::GRP_SIZE; s++) begin : g_tap
      if (g * ile_pkg::GRP_SIZE + s < ile_pkg::CAPACITY) begin : g_live
        assign gw[g][s] = cells[g * ile_pkg::GRP_SIZE + s];
      end else begin : g_pad
        assign gw[g][s] = '0;
      end
    end

    // first level: pick the word within each group
    always_ff @(posedge clk) begin
      if (load) begin
        grp[g] <= gw[g][pos[ile_pkg::SUB_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gsel <= pos[ile_pkg::SUB_W +: ile_pkg::GSEL_W];
    end
  end

  // second level: pick the group
  assign word = grp[gsel];

endmodule
`default_nettype wire

>>> src/indexed_list_engine_top.sv
`default_nettype none
// Indexed list engine: an ordered list of up to 256 signed 32-bit values.
// Request channel in_ch carries cmd (read, insert head, append tail,
// insert before position, delete), position and item_value. Result channel
// out_ch returns read_value, status and length, one result per request.
// Both channels use valid/ready; a transfer happens when both are high.
// Entries live in a row of cells; an insert or delete moves every cell at or
// past the position toward or from its neighbor in one update.
// Flow: a request waits in the request stage; as it leaves, the cells update
// and the first select level loads. It then waits in the select stage until
// the output register is free. A read goes through a two-level select (16
// words per group, then 16 groups); only the first level is registered.
// in_ch.ready drops while a request is in the update or select stage.
// A finished result waits in the output register; one further request is
// accepted and worked while it waits, and it then holds until the output
// register is free.
// Reset (rst, synchronous, active high) empties the list; cell contents are
// not cleared and are never read before being written.
module indexed_list_engine_top (
  input  wire logic  clk,
  input  wire logic  rst,
  ile_in_if.sink     in_ch,
  ile_out_if.source  out_ch
);

  // request stage
  logic                          a_valid;
  logic [2:0]                    a_cmd;
  logic [ile_pkg::POS_W-1:0]     a_pos;
  logic [ile_pkg::DATA_W-1:0]    a_val;

  // select stage
  logic                          b_valid;
  logic                          b_rd_ok;
  logic                          b_rd_bad;
  logic [1:0]                    b_status;
  logic [ile_pkg::CNT_W-1:0]     b_len;

  logic [ile_pkg::CNT_W-1:0]     count;
  logic [ile_pkg::CNT_W-1:0]     count_next;

  logic                          out_valid;
  logic [ile_pkg::DATA_W-1:0]    out_rv;
  logic [1:0]                    out_st;
  logic [ile_pkg::LEN_W-1:0]     out_len;

  logic                          accept;
  logic                          b_adv;
  logic [ile_pkg::CMP_W-1:0]     pos_x;
  logic [ile_pkg::CMP_W-1:0]     cnt_x;
  logic                          full;
  logic                          rd_ok;
  logic                          rd_bad;
  logic [1:0]                    status_next;
  ile_pkg::cell_ctl_t            ctl;
  logic [ile_pkg::CAPACITY-1:0][ile_pkg::DATA_W-1:0] cells;
  logic [ile_pkg::DATA_W-1:0]    word;

  assign in_ch.ready = !a_valid && !b_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b_adv       = b_valid && (!out_valid || out_ch.ready);

  assign pos_x = ile_pkg::CMP_W'(a_pos);
  assign cnt_x = ile_pkg::CMP_W'(count);
  assign full  = (count == ile_pkg::CNT_W'(ile_pkg::CAPACITY));

  always_comb begin
    ctl.op      = ile_pkg::CELL_HOLD;
    ctl.pos     = pos_x;
    ctl.value   = a_val;
    count_next  = count;
    status_next = ile_pkg::ST_DONE;
    rd_ok       = 1'b0;
    rd_bad      = 1'b0;
    case (a_cmd)
      ile_pkg::CMD_READ: begin
        if (pos_x < cnt_x) begin
          rd_ok = 1'b1;
        end else begin
          rd_bad      = 1'b1;
          status_next = ile_pkg::ST_BADPOS;
        end
      end
      ile_pkg::CMD_HEAD: begin
        if (full) begin
          status_next = ile_pkg::ST_FULL;
        end else begin
          ctl.op     = ile_pkg::CELL_INS;
          ctl.pos    = '0;
          count_next = count + 1'b1;
        end
      end
      ile_pkg::CMD_TAIL: begin
        if (full) begin
          status_next = ile_pkg::ST_FULL;
        end else begin
          ctl.op     = ile_pkg::CELL_INS;
          ctl.pos    = cnt_x;
          count_next = count + 1'b1;
        end
      end
      ile_pkg::CMD_BEFORE: begin
        if (pos_x > cnt_x) begin
          status_next = ile_pkg::ST_BADPOS;
        end else if (full) begin
          status_next = ile_pkg::ST_FULL;
        end else begin
          ctl.op     = ile_pkg::CELL_INS;
          count_next = count + 1'b1;
        end
      end
      ile_pkg::CMD_DELETE: begin
        if (pos_x >= cnt_x) begin
          status_next = ile_pkg::ST_BADPOS;
        end else begin
          ctl.op     = ile_pkg::CELL_DEL;
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
    if (!a_valid) begin
      ctl.op = ile_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
    logic [ile_pkg::DATA_W-1:0] left;
    logic [ile_pkg::DATA_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = a_val;
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == ile_pkg::CAPACITY - 1) begin : g_last
      assign right = cells[i];
    end else begin : g_mid_r
      assign right = cells[i+1];
    end
    ile_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (ile_pkg::CMP_W'(i)),
      .left  (left),
      .right (right),
      .data  (cells[i])
    );
  end

  ile_rdmux u_rdmux (
    .clk   (clk),
    .load  (a_valid),
    .pos   (pos_x),
    .cells (cells),
    .word  (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_valid) begin
        a_valid <= 1'b0;
      end
      if (a_valid) begin
        b_valid <= 1'b1;
        count   <= count_next;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd <= in_ch.cmd;
      a_pos <= in_ch.position;
      a_val <= in_ch.item_value;
    end
    if (a_valid) begin
      b_rd_ok  <= rd_ok;
      b_rd_bad <= rd_bad;
      b_status <= status_next;
      b_len    <= count_next;
    end
    if (b_adv) begin
      out_st  <= b_status;
      out_len <= ile_pkg::LEN_W'(b_len);
      if (b_rd_ok) begin
        out_rv <= word;
      end else if (b_rd_bad) begin
        out_rv <= '1;
      end else begin
        out_rv <= '0;
      end
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_value = out_rv;
  assign out_ch.status     = out_st;
  assign out_ch.length     = out_len;

endmodule
`default_nettype wire

>>> src/ile_checker.sv
`default_nettype none
module ile_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [1:0]                      status,
  input wire logic [ile_pkg::LEN_W-1:0]       length
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time: ready drops right after an accept
  a_in_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length <= ile_pkg::LEN_W'(ile_pkg::CAPACITY))
    else $error("length above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ile_pkg::ST_FULL |-> length == ile_pkg::LEN_W'(ile_pkg::CAPACITY))
    else $error("full status with room left");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .length    (out_ch.length)
);
`default_nettype wire
